/* rtl/rswt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rswt_pkg;

    localparam int SEQ_W = 16;
    localparam int OCC_W = 7;

    localparam logic [SEQ_W-1:0] JUMP_LIMIT_RST = 16'd64;

    typedef enum logic [2:0] {
        ST_STARTED  = 3'd0,
        ST_IN_ORDER = 3'd1,
        ST_GAP      = 3'd2,
        ST_DUP      = 3'd3,
        ST_RESET    = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [SEQ_W-1:0]  gap_count;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_OLD,
        S_RD_NEW,
        S_SCAN,
        S_APPEND,
        S_DONE
    } seq_state_t;

endpackage

`default_nettype wire

/* rtl/rswt_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface rswt_pkt_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] seq;

    modport source (output valid, output mode, output seq, input ready);
    modport sink   (input valid, input mode, input seq, output ready);
endinterface

interface rswt_res_if;
    logic               valid;
    logic               ready;
    rswt_pkg::status_t  status;
    logic [15:0]        gap_count;
    logic [6:0]         occupancy;

    modport source (output valid, output status, output gap_count, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input gap_count, input occupancy,
                    output ready);
endinterface

interface rswt_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/rswt_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module rswt_alu (
    input  wire logic [rswt_pkg::SEQ_W-1:0] a,
    input  wire logic [rswt_pkg::SEQ_W-1:0] b,
    output logic      [rswt_pkg::SEQ_W:0]   diff,
    output logic                            eq
);
    import rswt_pkg::*;

    // Top bit of diff is the borrow: set when a < b
    assign diff = {1'b0, a} - {1'b0, b};
    assign eq   = (diff[SEQ_W-1:0] == '0);

endmodule

`default_nettype wire

/* rtl/rswt_window_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module rswt_window_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [AW-1:0]                 waddr,
    input  wire logic [rswt_pkg::SEQ_W-1:0]    wdata,
    input  wire logic [AW-1:0]                 raddr,
    output logic      [rswt_pkg::SEQ_W-1:0]    rdata
);
    import rswt_pkg::*;

    logic [SEQ_W-1:0] mem [DEPTH];
    logic [SEQ_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/rswt_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module rswt_seq #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_mode,
    input  wire logic [rswt_pkg::SEQ_W-1:0]    in_seq,
    output logic                               in_ready,
    input  wire logic [rswt_pkg::SEQ_W-1:0]    jump_limit,
    output logic                               done,
    output rswt_pkg::result_t                  result,
    input  wire logic                          take,
    output logic                               mem_we,
    output logic      [AW-1:0]                 mem_waddr,
    output logic      [rswt_pkg::SEQ_W-1:0]    mem_wdata,
    output logic      [AW-1:0]                 mem_raddr,
    input  wire logic [rswt_pkg::SEQ_W-1:0]    mem_rdata
);
    import rswt_pkg::*;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL      = CW'(DEPTH);

    seq_state_t       state_reg,  state_next;
    logic [AW-1:0]    head_reg,   head_next;
    logic [AW-1:0]    tail_reg,   tail_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic [AW-1:0]    ptr_reg,    ptr_next;
    logic [CW-1:0]    idx_reg,    idx_next;
    logic [SEQ_W-1:0] seq_reg,    seq_next;
    logic [SEQ_W-1:0] gap_reg,    gap_next;
    logic             below_reg,  below_next;
    result_t          res_reg,    res_next;

    logic [SEQ_W-1:0] alu_a;
    logic [SEQ_W-1:0] alu_b;
    logic [SEQ_W:0]   alu_diff;
    logic             alu_eq;
    logic             in_fire;
    logic [AW-1:0]    newest_slot;
    logic [AW-1:0]    ptr_inc;
    logic [AW-1:0]    tail_inc;
    logic [AW-1:0]    head_inc;
    logic             too_far;

    rswt_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .eq   (alu_eq)
    );

    assign in_fire     = in_valid && in_ready;
    assign newest_slot = (tail_reg == '0) ? LAST_SLOT : tail_reg - 1'b1;
    assign ptr_inc     = (ptr_reg  == LAST_SLOT) ? '0 : ptr_reg  + 1'b1;
    assign tail_inc    = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
    assign head_inc    = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign too_far     = !alu_diff[SEQ_W] && (alu_diff[SEQ_W-1:0] > jump_limit);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        seq_next   = seq_reg;
        gap_next   = gap_reg;
        below_next = below_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        done       = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = tail_reg;
        mem_wdata  = seq_reg;
        mem_raddr  = head_reg;
        alu_a      = seq_reg;
        alu_b      = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    seq_next = in_seq;
                    if (in_mode)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                        res_next   = '{ST_CLEARED, '0, '0};
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = in_seq;
                        head_next  = '0;
                        tail_next  = AW'(1);
                        count_next = CW'(1);
                        res_next   = '{ST_STARTED, '0, OCC_W'(1)};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // fetch oldest entry
                        mem_raddr  = head_reg;
                        state_next = S_RD_OLD;
                    end
                end
            end

            S_RD_OLD:
            begin
                below_next = alu_diff[SEQ_W];
                mem_raddr  = newest_slot;
                state_next = S_RD_NEW;
            end

            S_RD_NEW:
            begin
                if (below_reg || too_far)
                begin
                    // restart the window with this number
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = seq_reg;
                    head_next  = '0;
                    tail_next  = AW'(1);
                    count_next = CW'(1);
                    res_next   = '{ST_RESET, '0, OCC_W'(1)};
                    state_next = S_DONE;
                end
                else
                begin
                    if (!alu_diff[SEQ_W] && (alu_diff[SEQ_W-1:1] != '0))
                    begin
                        gap_next = alu_diff[SEQ_W-1:0] - 1'b1;
                    end
                    else
                    begin
                        gap_next = '0;
                    end
                    mem_raddr  = head_reg;
                    ptr_next   = head_reg;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (alu_eq)
                begin
                    res_next   = '{ST_DUP, '0, OCC_W'(count_reg)};
                    state_next = S_DONE;
                end
                else if (idx_reg == count_reg - 1'b1)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    ptr_next  = ptr_inc;
                    mem_raddr = ptr_inc;
                end
            end

            S_APPEND:
            begin
                mem_we    = 1'b1;
                mem_waddr = tail_reg;
                mem_wdata = seq_reg;
                tail_next = tail_inc;
                // full window: drop the oldest entry, count stays
                if (count_reg == FULL)
                begin
                    head_next = head_inc;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
                res_next.status    = (gap_reg != '0) ? ST_GAP : ST_IN_ORDER;
                res_next.gap_count = gap_reg;
                res_next.occupancy = OCC_W'(count_next);
                state_next         = S_DONE;
            end

            S_DONE:
            begin
                done = 1'b1;
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        idx_reg   <= idx_next;
        seq_reg   <= seq_next;
        gap_reg   <= gap_next;
        below_reg <= below_next;
        res_reg   <= res_next;
    end

    assign result = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("window count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty window with head and tail apart");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_mode) |=> (count_reg == '0 && state_reg == S_DONE))
        else $error("clear did not empty the window");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg < count_reg))
        else $error("scan ran past the window");

    a_done_held: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !take) |=> (done && $stable(res_reg)))
        else $error("result dropped while waiting for output slot");

endmodule

`default_nettype wire

/* rtl/rx_sequence_window_tracker.sv */
// Sequence window tracker for received packets.
//
// pkt: input transactions (mode, seq). mode 1 clears the window, mode 0
//      submits a received sequence number.
// res: one result transaction per input (status, gap_count, occupancy),
//      held in an output register until the sink takes it.
// cfg: write transaction for the forward jump limit; always ready, applied
//      the next cycle. Write only while no input transaction is in flight.
//
// Per input: a clear or the first number into an empty window goes straight to
// the result. Otherwise the oldest entry is read, then the newest; a number below
// the oldest or beyond the newest by more than the jump limit resets the window.
// Else the held entries are compared in turn up to a match (a duplicate), and a
// number with no match is appended. The window is a single-port-read
// memory compared one entry per cycle through one shared subtract/compare
// unit. pkt.ready is high only while the sequencer is idle, which it enters as
// the result moves to the output register: one input is handled at a time.
// Reset empties the window and sets the jump limit to 64. If res is stalled
// the finished result waits in the sequencer and pkt.ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module rx_sequence_window_tracker #(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rswt_pkt_if.sink   pkt,
    rswt_res_if.source res,
    rswt_cfg_if.sink   cfg
);
    import rswt_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    logic [SEQ_W-1:0] jump_limit_reg;
    logic             res_valid_reg;
    result_t          res_data_reg;

    logic             done;
    logic             take;
    result_t          result;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [SEQ_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [SEQ_W-1:0] mem_rdata;

    assign cfg.ready = 1'b1;
    assign take      = !res_valid_reg || res.ready;

    rswt_window_mem #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rswt_seq #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pkt.valid),
        .in_mode     (pkt.mode),
        .in_seq      (pkt.seq),
        .in_ready    (pkt.ready),
        .jump_limit  (jump_limit_reg),
        .done        (done),
        .result      (result),
        .take        (take),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_limit_reg <= JUMP_LIMIT_RST;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                jump_limit_reg <= cfg.data;
            end
            if (take)
            begin
                res_valid_reg <= done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && done)
        begin
            res_data_reg <= result;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.status    = res_data_reg.status;
    assign res.gap_count = res_data_reg.gap_count;
    assign res.occupancy = res_data_reg.occupancy;

endmodule

`default_nettype wire
